### hdl/kch_pkg.sv
package kch_pkg;

    localparam int NumBuckets = 4096;
    localparam int IdxW       = 12;
    localparam int MaxBases   = 32;
    localparam int LenW       = 6;
    localparam int KeyW       = 64;
    localparam int CntW       = 24;
    localparam int CfgW       = 13;
    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD     = 2'd2,
        ST_TOOLONG = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  base_char;
        logic        last_base;
        logic [23:0] seq_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [11:0] bucket_index;
        logic [23:0] key_count;
        logic [23:0] first_id;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic absorb;      // take one base into crc and key
        logic key_reset;   // restart key accumulation
        logic mod_start;   // begin hash modulo
        logic mod_step;    // advance the restoring division
        logic probe_init;  // position <- home bucket
        logic rd;          // read slot at position
        logic advance;     // position <- next with wrap
        logic write_new;   // write new entry at position
        logic write_inc;   // write incremented count at position
        logic clr_start;   // begin clearing sweep
        logic clr_step;    // clear one valid bit
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       key_err;
        logic [1:0] err_code;
        logic       slot_valid;
        logic       slot_match;
        logic       cnt_sat;
        logic       probe_done;  // every bucket visited
        logic       clr_last;
    } t_stat;

    // One CRC-32 byte update (reflected).
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hdl/kmer_count_hash_table_top.sv
// k-mer counting hash table.
// Input: a key streams in one ASCII base per transfer (start high, busy low),
// with last_base on the final base; operation on that base selects insert
// or lookup. Clear may be sent on any transfer.
// For a non-final base busy stays low. A key end keeps busy high until its
// result goes out: first the hash modulo (two quotient bits per cycle, home
// bucket loaded on its last step), then a read/wait/compare loop per bucket
// probed on the slot memory. Clear sweeps the valid flags one bucket per
// cycle. The next transfer can be taken at the edge that takes the result.
// Results appear on o_strobe for exactly one cycle; the receiver cannot
// stall, so the result is always taken.
// Configuration: i_cfg_we with i_cfg_data writes the bucket count; the user
// must do so only while idle, which the block itself does not enforce.
// Reset (i_rst_n low, synchronous) drops any partial key and sets the bucket
// count to 4096; a clearing pass with busy high then empties the table.
module kmer_count_hash_table_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  kch_pkg::t_in             i_item,
    input  logic                     i_cfg_we,
    input  logic [kch_pkg::CfgW-1:0] i_cfg_data,
    output logic                     o_strobe,
    output kch_pkg::t_out            o_result
);
    import kch_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_out  dp_out;
    logic [1:0] rstat;
    logic found, zero_out, cnt_one;

    kch_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy,
        .i_in(i_item), .i_stat(stat), .o_cmd(cmd),
        .o_strobe, .o_rstat(rstat), .o_found(found),
        .o_zero_out(zero_out), .o_cnt_one(cnt_one)
    );

    kch_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_in(i_item), .i_cmd(cmd), .o_stat(stat),
        .o_out(dp_out)
    );

    // Result field selection.
    always_comb begin
        o_result.status = rstat;
        o_result.found  = found;
        if (zero_out) begin
            o_result.bucket_index = '0;
            o_result.key_count    = '0;
            o_result.first_id     = '0;
        end else if (!found && !cnt_one) begin
            o_result.bucket_index = dp_out.bucket_index;
            o_result.key_count    = '0;
            o_result.first_id     = '0;
        end else begin
            o_result.bucket_index = dp_out.bucket_index;
            o_result.key_count    = dp_out.key_count;
            o_result.first_id     = dp_out.first_id;
        end
    end

endmodule

### hdl/kch_ctrl.sv
module kch_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  kch_pkg::t_in   i_in,
    input  kch_pkg::t_stat i_stat,
    output kch_pkg::t_cmd  o_cmd,
    output logic           o_strobe,
    output logic [1:0]     o_rstat,
    output logic           o_found,
    output logic           o_zero_out,
    output logic           o_cnt_one
);
    import kch_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_MOD, S_PROBE_RD, S_PROBE_WAIT, S_PROBE_CHK, S_CLR
    } t_state;

    t_state      r_state;
    logic [3:0]  r_cnt;
    logic        r_op_ins;
    logic        accept;
    logic        n_strobe;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Command decode and result strobe.
    always_comb begin
        o_cmd = '0;
        n_strobe = 1'b0;
        case (r_state)
            S_INIT:       o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                if (accept) begin
                    if (i_in.operation == OP_CLEAR) begin
                        o_cmd.clr_start = 1'b1;
                        o_cmd.key_reset = 1'b1;
                    end else if (i_in.operation != OP_NONE) begin
                        o_cmd.absorb    = 1'b1;
                        o_cmd.mod_start = i_in.last_base;
                    end
                end
            end
            S_MOD:        o_cmd.mod_step = 1'b1;
            S_PROBE_RD:   o_cmd.rd = 1'b1;
            S_PROBE_WAIT: begin
                if (r_cnt == 4'd15) begin
                    // Errored key: drop it as its result goes out.
                    o_cmd.key_reset = 1'b1;
                    n_strobe = 1'b1;
                end
            end
            S_PROBE_CHK: begin
                if (!i_stat.slot_valid) begin
                    o_cmd.write_new = r_op_ins;
                    o_cmd.key_reset = 1'b1;
                    n_strobe = 1'b1;
                end else if (i_stat.slot_match) begin
                    o_cmd.write_inc = r_op_ins && !i_stat.cnt_sat;
                    o_cmd.key_reset = 1'b1;
                    n_strobe = 1'b1;
                end else if (i_stat.probe_done) begin
                    o_cmd.key_reset = 1'b1;
                    n_strobe = 1'b1;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                n_strobe = i_stat.clr_last;
            end
            default: ;
        endcase
        if (r_state == S_MOD && r_cnt == 4'd12) begin
            o_cmd.probe_init = 1'b1;
        end
    end

    // Sequencer state and registered result control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_cnt      <= '0;
            r_op_ins   <= 1'b0;
            o_strobe   <= 1'b0;
            o_rstat    <= '0;
            o_found    <= 1'b0;
            o_zero_out <= 1'b0;
            o_cnt_one  <= 1'b0;
        end else begin
            o_strobe <= n_strobe;
            case (r_state)
                S_INIT: begin
                    // Clearing pass after reset, no result.
                    if (i_stat.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && i_in.operation == OP_CLEAR) begin
                        r_state <= S_CLR;
                    end else if (accept && i_in.operation != OP_NONE && i_in.last_base) begin
                        r_op_ins <= (i_in.operation == OP_INSERT);
                        if (i_stat.key_err) begin
                            // Error code already final after this base.
                            r_state <= S_PROBE_WAIT;
                            r_cnt   <= 4'd15;
                        end else begin
                            r_state <= S_MOD;
                            r_cnt   <= '0;
                        end
                    end
                end
                S_MOD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd12) begin
                        r_state <= S_PROBE_RD;
                    end
                end
                S_PROBE_RD:   r_state <= S_PROBE_WAIT;
                S_PROBE_WAIT: begin
                    if (r_cnt == 4'd15) begin
                        // Errored key: report and drop it.
                        o_rstat    <= i_stat.err_code;
                        o_found    <= 1'b0;
                        o_zero_out <= 1'b1;
                        o_cnt_one  <= 1'b0;
                        r_cnt      <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_PROBE_CHK;
                    end
                end
                S_PROBE_CHK: begin
                    if (!i_stat.slot_valid) begin
                        o_rstat    <= ST_OK;
                        o_found    <= 1'b0;
                        o_zero_out <= 1'b0;
                        o_cnt_one  <= r_op_ins;
                        r_state    <= S_IDLE;
                    end else if (i_stat.slot_match) begin
                        o_rstat    <= ST_OK;
                        o_found    <= 1'b1;
                        o_zero_out <= 1'b0;
                        o_cnt_one  <= 1'b0;
                        r_state    <= S_IDLE;
                    end else if (i_stat.probe_done) begin
                        o_rstat    <= ST_FULL;
                        o_found    <= 1'b0;
                        o_zero_out <= 1'b1;
                        o_cnt_one  <= 1'b0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_PROBE_RD;
                    end
                end
                S_CLR: begin
                    if (i_stat.clr_last) begin
                        o_rstat    <= ST_OK;
                        o_found    <= 1'b0;
                        o_zero_out <= 1'b1;
                        o_cnt_one  <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/kch_dp.sv
module kch_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [kch_pkg::CfgW-1:0] i_cfg_data,
    input  kch_pkg::t_in          i_in,
    input  kch_pkg::t_cmd         i_cmd,
    output kch_pkg::t_stat        o_stat,
    output kch_pkg::t_out         o_out
);
    import kch_pkg::*;

    // Configuration and key accumulation state.
    logic [CfgW-1:0]  r_cfg;
    logic [31:0]      r_crc;
    logic [KeyW-1:0]  r_key;
    logic [LenW-1:0]  r_len;
    logic [1:0]       r_err;
    logic [CntW-1:0]  r_sid;

    // Modulo unit and probe position.
    logic [23:0]      r_rem;
    logic [23:0]      r_quo;
    logic [IdxW:0]    r_nb;
    logic [IdxW-1:0]  r_pos;
    logic [IdxW:0]    r_visits;

    // Clear sweep.
    logic [IdxW-1:0]  r_clr;

    // Slot memories, valid flags included.
    logic                  mem_valid [NumBuckets];
    logic [KeyW+LenW-1:0]  mem_key [NumBuckets];
    logic [2*CntW-1:0]     mem_cf  [NumBuckets];
    logic [KeyW+LenW-1:0]  r_rd_key;
    logic [2*CntW-1:0]     r_rd_cf;
    logic                  r_rd_valid;

    logic [1:0]  code;
    logic        bad;
    logic [1:0]  err_n;
    logic [24:0] trial;
    logic [IdxW:0] nb_eff;
    logic [31:0] crc_next;

    always_comb begin
        bad = 1'b0;
        code = 2'd0;
        case (i_in.base_char)
            8'h41: code = 2'd0;
            8'h43: code = 2'd1;
            8'h47: code = 2'd2;
            8'h54: code = 2'd3;
            default: bad = 1'b1;
        endcase
        err_n = r_err;
        if (r_err == 2'd0) begin
            if (bad) err_n = ST_BAD;
            else if (r_len >= LenW'(MaxBases)) err_n = ST_TOOLONG;
        end
        if (r_cfg == '0) nb_eff = (IdxW+1)'(1);
        else if (r_cfg > CfgW'(NumBuckets)) nb_eff = (IdxW+1)'(NumBuckets);
        else nb_eff = r_cfg[IdxW:0];
        trial = {1'b0, r_rem[22:0], r_quo[23]} - {12'd0, r_nb};
        crc_next = crc_byte(r_crc, i_in.base_char);
    end

    assign o_stat.key_err    = (err_n != 2'd0);
    assign o_stat.err_code   = r_err;
    assign o_stat.slot_valid = r_rd_valid;
    assign o_stat.slot_match = (r_rd_key == {r_key, r_len});
    assign o_stat.cnt_sat    = (r_rd_cf[2*CntW-1:CntW] == CntMax);
    assign o_stat.probe_done = (r_visits >= r_nb - (IdxW+1)'(1));
    assign o_stat.clr_last   = (r_clr == {IdxW{1'b1}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgW'(NumBuckets);
            r_crc <= '1;
            r_key <= '0;
            r_len <= '0;
            r_err <= '0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (i_cmd.absorb) begin
                r_crc <= crc_next;
                r_err <= err_n;
                r_sid <= i_in.seq_id;
                if (r_err == 2'd0 && !bad && r_len < LenW'(MaxBases)) begin
                    r_key <= r_key | (KeyW'(code) << {r_len[4:0], 1'b0});
                    r_len <= r_len + LenW'(1);
                end
            end
            if (i_cmd.key_reset) begin
                r_crc <= '1;
                r_key <= '0;
                r_len <= '0;
                r_err <= '0;
            end
        end
    end

    // Restoring division: two steps per cycle over 24 bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_quo <= ~crc_next[23:0];
            r_rem <= '0;
            r_nb  <= nb_eff;
        end else if (i_cmd.mod_step) begin
            logic [23:0] rem1;
            logic [23:0] quo1;
            logic [24:0] t2;
            if (!trial[24]) rem1 = trial[23:0];
            else rem1 = {r_rem[22:0], r_quo[23]};
            quo1 = {r_quo[22:0], 1'b0};
            t2 = {1'b0, rem1[22:0], quo1[23]} - {12'd0, r_nb};
            if (!t2[24]) r_rem <= t2[23:0];
            else r_rem <= {rem1[22:0], quo1[23]};
            r_quo <= {quo1[22:0], 1'b0};
        end
    end

    // Probe position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_pos    <= r_rem[IdxW-1:0];
            r_visits <= '0;
        end else if (i_cmd.advance) begin
            r_visits <= r_visits + (IdxW+1)'(1);
            if ({1'b0, r_pos} + (IdxW+1)'(1) >= r_nb) r_pos <= '0;
            else r_pos <= r_pos + IdxW'(1);
        end
    end

    // Clearing sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else begin
            if (i_cmd.clr_start) r_clr <= '0;
            if (i_cmd.clr_step) r_clr <= r_clr + IdxW'(1);
        end
    end

    // Slot memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key   <= mem_key[r_pos];
            r_rd_cf    <= mem_cf[r_pos];
            r_rd_valid <= mem_valid[r_pos];
        end
        if (i_cmd.clr_step) begin
            mem_valid[r_clr] <= 1'b0;
        end else if (i_cmd.write_new) begin
            mem_valid[r_pos] <= 1'b1;
        end
        if (i_cmd.write_new) begin
            mem_key[r_pos] <= {r_key, r_len};
            mem_cf[r_pos]  <= {CntW'(1), r_sid};
        end else if (i_cmd.write_inc) begin
            mem_cf[r_pos]  <= {r_rd_cf[2*CntW-1:CntW] + CntW'(1), r_rd_cf[CntW-1:0]};
        end
    end

    // Result register; the controller supplies status and found.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_new || i_cmd.write_inc || i_cmd.key_reset || i_cmd.clr_start) begin
            o_out.status       <= ST_OK;
            o_out.found        <= 1'b0;
            o_out.bucket_index <= r_pos;
            if (i_cmd.write_new) begin
                o_out.key_count <= CntW'(1);
                o_out.first_id  <= r_sid;
            end else if (i_cmd.write_inc) begin
                o_out.key_count <= r_rd_cf[2*CntW-1:CntW] + CntW'(1);
                o_out.first_id  <= r_rd_cf[CntW-1:0];
            end else begin
                o_out.key_count <= r_rd_cf[2*CntW-1:CntW];
                o_out.first_id  <= r_rd_cf[CntW-1:0];
            end
        end
    end

endmodule

### hdl/kch_checker.sv
module kch_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input kch_pkg::t_in        i_item,
    input logic                o_strobe,
    input kch_pkg::t_out       o_result
);
    import kch_pkg::*;

    // A clear transfer makes the block busy.
    a_clr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.operation == OP_CLEAR |=> busy)
        else $error("clear not started");

    // Strobes are single-cycle pulses after a busy period.
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe longer than one cycle");

    // Errors and full report zero payload.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != ST_OK |-> o_result.key_count == '0 && !o_result.found)
        else $error("error result has payload");

    // A found key always has a nonzero count.
    a_found_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.found |-> o_result.key_count != '0)
        else $error("found with zero count");

endmodule

bind kmer_count_hash_table_top kch_checker u_kch_checker (
    .i_clk, .i_rst_n, .start, .busy, .i_item, .o_strobe, .o_result
);

### bench/testbench.sv
module testbench;
    import kch_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in               i_item = '0;
    logic              i_cfg_we = 1'b0;
    logic [CfgW-1:0]   i_cfg_data = '0;
    logic              o_strobe;
    t_out              o_result;

    kmer_count_hash_table_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the table and of the key being assembled.
    logic              tbl_valid [NumBuckets];
    logic [KeyW-1:0]   tbl_key   [NumBuckets];
    logic [LenW-1:0]   tbl_len   [NumBuckets];
    logic [CntW-1:0]   tbl_count [NumBuckets];
    logic [CntW-1:0]   tbl_first [NumBuckets];
    logic [31:0]       crc_acc;
    logic [KeyW-1:0]   packed_key;
    int                packed_len;
    logic [1:0]        key_fault;
    logic [CfgW-1:0]   buckets_reg;

    t_in   pending_items [$];
    t_out  expected_results [$];
    int    mismatches = 0;
    int    send_idle_pct = 0;
    int    item_total = 0;

    function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] ch);
        logic [31:0] c;
        c = crc ^ {24'd0, ch};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void restart_key();
        crc_acc    = 32'hFFFFFFFF;
        packed_key = '0;
        packed_len = 0;
        key_fault  = ST_OK;
    endfunction

    // Work out the result, if any, that one accepted transfer causes.
    function automatic void predict_count(t_in it);
        t_out r;
        int   code;
        int   nb;
        int   pos;
        bit   hit;
        bit   empty;
        r = '0;
        hit = 0;
        empty = 0;
        if (it.operation == OP_NONE) return;
        if (it.operation == OP_CLEAR) begin
            for (int i = 0; i < NumBuckets; i++) tbl_valid[i] = 1'b0;
            restart_key();
            expected_results.push_back(r);
            return;
        end
        crc_acc = crc32_update(crc_acc, it.base_char);
        case (it.base_char)
            8'h41: code = 0;
            8'h43: code = 1;
            8'h47: code = 2;
            8'h54: code = 3;
            default: code = -1;
        endcase
        if (code < 0) begin
            if (key_fault == ST_OK) key_fault = ST_BAD;
        end else if (packed_len >= MaxBases) begin
            if (key_fault == ST_OK) key_fault = ST_TOOLONG;
        end else begin
            packed_key |= KeyW'(code) << (2 * packed_len);
            packed_len++;
        end
        if (!it.last_base) return;
        if (key_fault != ST_OK) begin
            r.status = key_fault;
            expected_results.push_back(r);
            restart_key();
            return;
        end
        nb = int'(buckets_reg);
        if (nb == 0) nb = 1;
        if (nb > NumBuckets) nb = NumBuckets;
        pos = int'((~crc_acc) & 32'hFFFFFF) % nb;
        for (int n = 0; n < nb; n++) begin
            if (!tbl_valid[pos]) begin
                empty = 1;
                break;
            end
            if (tbl_len[pos] == packed_len && tbl_key[pos] == packed_key) begin
                hit = 1;
                break;
            end
            pos = (pos + 1 >= nb) ? 0 : pos + 1;
        end
        if (hit) begin
            if (it.operation == OP_INSERT && tbl_count[pos] != CntMax)
                tbl_count[pos]++;
            r.found = 1'b1;
            r.bucket_index = pos[IdxW-1:0];
            r.key_count = tbl_count[pos];
            r.first_id = tbl_first[pos];
        end else if (empty) begin
            r.bucket_index = pos[IdxW-1:0];
            if (it.operation == OP_INSERT) begin
                tbl_valid[pos] = 1'b1;
                tbl_key[pos]   = packed_key;
                tbl_len[pos]   = LenW'(packed_len);
                tbl_count[pos] = CntW'(1);
                tbl_first[pos] = it.seq_id;
                r.key_count = CntW'(1);
                r.first_id = it.seq_id;
            end
        end else begin
            r.status = ST_FULL;
        end
        expected_results.push_back(r);
        restart_key();
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Driver: a transfer happens when start is high and busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) predict_count(i_item);
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest expected result.
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                w = expected_results.pop_front();
                if (o_result.status != w.status)
                    report_mismatch("status", int'(o_result.status), int'(w.status));
                if (o_result.found != w.found)
                    report_mismatch("found", int'(o_result.found), int'(w.found));
                if (o_result.bucket_index != w.bucket_index)
                    report_mismatch("bucket_index", int'(o_result.bucket_index),
                                    int'(w.bucket_index));
                if (o_result.key_count != w.key_count)
                    report_mismatch("key_count", int'(o_result.key_count),
                                    int'(w.key_count));
                if (o_result.first_id != w.first_id)
                    report_mismatch("first_id", int'(o_result.first_id),
                                    int'(w.first_id));
            end
        end
    end

    function automatic void queue_item(t_op op, logic [7:0] ch, logic last, logic [23:0] sid);
        t_in it;
        it.operation = op;
        it.base_char = ch;
        it.last_base = last;
        it.seq_id = sid;
        pending_items.push_back(it);
        if (op != OP_NONE) item_total++;
    endfunction

    // Queue one key; the operation rides on the final base.
    function automatic void queue_key(string s, t_op op, logic [23:0] sid);
        for (int i = 0; i < s.len(); i++) begin
            if (i == s.len() - 1)
                queue_item(op, s[i], 1'b1, sid);
            else
                queue_item($urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT, s[i], 1'b0,
                           24'($urandom));
        end
    endfunction

    function automatic string random_key(int len);
        string s;
        string acgt;
        int    k;
        acgt = "ACGT";
        s = "";
        for (int i = 0; i < len; i++) begin
            k = $urandom_range(0, 3);
            s = {s, acgt.substr(k, k)};
        end
        return s;
    endfunction

    function automatic logic [7:0] non_base();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == 8'h41 || c == 8'h43 || c == 8'h47 || c == 8'h54);
        return c;
    endfunction

    // Wait until every queued transfer and every result is done.
    task automatic drain();
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [CfgW-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        buckets_reg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CfgW-1:0] cfgs [9];
        string pool [$];
        string s;
        int    target;
        int    r;
        cfgs = '{13'd16, 13'd4096, 13'd1, 13'd37, 13'd8191, 13'd0, 13'd3000,
                 13'd5000, 13'd4096};
        for (int i = 0; i < NumBuckets; i++) tbl_valid[i] = 1'b0;
        restart_key();
        buckets_reg = 13'd4096;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first at the reset bucket count, then at 1, 0 and 8191.
        write_buckets(13'd4096);
        queue_key("A", OP_INSERT, 24'hFFFFFF);
        queue_key("A", OP_INSERT, 24'h000000);
        queue_key("A", OP_LOOKUP, 24'h123456);
        queue_key("C", OP_LOOKUP, 24'h1);
        queue_key({32{"T"}}, OP_INSERT, 24'h2);
        queue_key({33{"G"}}, OP_INSERT, 24'h3);
        queue_item(OP_INSERT, 8'h00, 1'b0, 24'h0);
        queue_item(OP_INSERT, 8'hFF, 1'b1, 24'hFFFFFF);
        queue_key({{33{"C"}}, "x"}, OP_LOOKUP, 24'h4);
        queue_item(OP_NONE, 8'h41, 1'b1, 24'h5);
        queue_item(OP_INSERT, 8'h43, 1'b0, 24'h6);
        queue_item(OP_CLEAR, 8'h41, 1'b0, 24'h7);
        queue_key("A", OP_LOOKUP, 24'h8);
        drain();
        write_buckets(13'd1);
        queue_key("A", OP_INSERT, 24'h9);
        queue_key("C", OP_INSERT, 24'hA);
        queue_key("G", OP_LOOKUP, 24'hB);
        queue_key("A", OP_LOOKUP, 24'hC);
        drain();
        write_buckets(13'd0);
        queue_key("A", OP_INSERT, 24'hD);
        drain();
        write_buckets(13'd8191);
        queue_key("A", OP_LOOKUP, 24'hE);
        queue_item(OP_CLEAR, 8'h00, 1'b1, 24'h0);
        drain();

        // Random phases: sender idle 19%, then 73%, then never.
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 19 : (ph < 6) ? 73 : 0;
            write_buckets(cfgs[ph]);
            pool.delete();
            for (int k = 0; k < 20; k++) pool.push_back(random_key($urandom_range(1, 10)));
            pool.push_back(random_key(32));
            if ($urandom_range(0, 1))
                queue_item(OP_CLEAR, 8'($urandom), 1'($urandom), 24'($urandom));
            target = item_total + 180;
            while (item_total < target) begin
                r = $urandom_range(0, 99);
                s = pool[$urandom_range(0, pool.size() - 1)];
                if (r < 4) begin
                    s = random_key($urandom_range(33, 36));
                end else if (r < 8) begin
                    s[$urandom_range(0, s.len() - 1)] = non_base();
                end else if (r < 10) begin
                    queue_item(OP_NONE, 8'($urandom), 1'($urandom), 24'($urandom));
                end else if (r < 11) begin
                    queue_key(random_key($urandom_range(1, 5)), OP_INSERT, 24'($urandom));
                    pending_items.pop_back();
                    queue_item(OP_CLEAR, 8'($urandom), 1'($urandom), 24'($urandom));
                    continue;
                end
                queue_key(s, ($urandom_range(0, 2) == 0) ? OP_LOOKUP : OP_INSERT,
                          24'($urandom));
            end
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (expected_results.size() > 0)
            report_mismatch("results still expected", expected_results.size(), 0);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #30000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
